// ----- rtl/top_scores_sorted_insert_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the top-scores core
// Shared wrappers that fix the clock and reset used by the assertions.
// ----------------------------------------------------------------------------
`ifndef TOP_SCORES_SORTED_INSERT_CORE_ASSERT_SVH
`define TOP_SCORES_SORTED_INSERT_CORE_ASSERT_SVH

// Checked on every rising edge, skipped while reset is applied.
`define TSSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define TSSI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/tssi_pkg.sv -----
// ----------------------------------------------------------------------------
// tssi_pkg
// Sizes, request and status codes and the store command for the core.
// ----------------------------------------------------------------------------
package tssi_pkg;

  // Capacity of the score store and the widths that follow from it.
  localparam int MaxEntries = 10;
  localparam int CntW       = $clog2(MaxEntries + 1);
  localparam int IdxW       = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;

  // Fixed field widths.
  localparam int ScoreW    = 32;
  localparam int CntOutW   = 4;

  // Request codes.
  localparam logic ReqInsert = 1'b0;
  localparam logic ReqDrain  = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    StInserted  = 2'd0,
    StDuplicate = 2'd1,
    StTooLow    = 2'd2,
    StDrained   = 2'd3
  } status_e;

  // Write command to the store: place the new score at slot and shift
  // the neighbors, either down over the dropped minimum or up to grow.
  typedef struct packed {
    logic            wr_en;
    logic            drop_low;
    logic [IdxW-1:0] slot;
  } store_cmd_t;

endpackage

// ----- rtl/tssi_store.sv -----
// ----------------------------------------------------------------------------
// tssi_store
// Sorted score registers with one indexed read port and a registered
// shift-and-place write.
// ----------------------------------------------------------------------------
module tssi_store (
  input  logic                                clk_i,
  input  tssi_pkg::store_cmd_t                cmd_i,
  input  logic signed [tssi_pkg::ScoreW-1:0]  score_i,
  input  logic        [tssi_pkg::IdxW-1:0]    rd_idx_i,
  output logic signed [tssi_pkg::ScoreW-1:0]  rd_data_o
);

  logic signed [tssi_pkg::ScoreW-1:0] ent_q [tssi_pkg::MaxEntries];
  logic signed [tssi_pkg::ScoreW-1:0] ent_d [tssi_pkg::MaxEntries];

  // Next value of each entry: hold, take the new score, or take a neighbor.
  for (genvar g = 0; g < tssi_pkg::MaxEntries; g++) begin : g_ent
    always_comb begin
      ent_d[g] = ent_q[g];
      if (cmd_i.wr_en) begin
        if (cmd_i.slot == tssi_pkg::IdxW'(g)) begin
          ent_d[g] = score_i;
        end else if (cmd_i.drop_low) begin
          if (g < tssi_pkg::MaxEntries - 1) begin
            if (tssi_pkg::IdxW'(g) < cmd_i.slot) begin
              ent_d[g] = ent_q[(g < tssi_pkg::MaxEntries - 1) ? g + 1 : g];
            end
          end
        end else begin
          if (g > 0) begin
            if (tssi_pkg::IdxW'(g) > cmd_i.slot) begin
              ent_d[g] = ent_q[(g > 0) ? g - 1 : g];
            end
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      ent_q[g] <= ent_d[g];
    end
  end

  // Read port; an index past the store reads as zero.
  always_comb begin
    rd_data_o = '0;
    if (32'(rd_idx_i) < tssi_pkg::MaxEntries) begin
      rd_data_o = ent_q[rd_idx_i];
    end
  end

endmodule

// ----- rtl/top_scores_sorted_insert_core.sv -----
// ----------------------------------------------------------------------------
// top_scores_sorted_insert_core
// Keeps the ten highest distinct scores in ascending order; inserts and
// drains them on request.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat is taken when start_i is high and busy_o is low. An
//   insert (req_type_i = 0) walks the kept entries from the smallest up
//   through one shared signed comparator, one entry per cycle, then places
//   the score. Its single result strobes res_valid_o, registered after the
//   search or the placement, with is_last_o set and score_out_o zero.
//   A drain (req_type_i = 1) emits one result beat per kept score on
//   consecutive cycles, smallest first; the first beat is registered out
//   of the drain state. The last one carries is_last_o and count_after_o
//   = 0, and the store is then empty. A drain of an empty store gives no
//   beat at all. busy_o stays high while a request is at work.
//   Each result stands for one cycle only; the receiver cannot stall it.
//   Reset empties the store at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "top_scores_sorted_insert_core_assert.svh"

module top_scores_sorted_insert_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic                                 req_type_i,
  input  logic signed [tssi_pkg::ScoreW-1:0]   score_i,
  output logic                                 res_valid_o,
  output logic signed [tssi_pkg::ScoreW-1:0]   score_out_o,
  output logic                                 is_last_o,
  output logic        [1:0]                    status_o,
  output logic        [tssi_pkg::CntOutW-1:0]  count_after_o
);

  localparam logic [1:0] SIdle   = 2'd0;
  localparam logic [1:0] SSearch = 2'd1;
  localparam logic [1:0] SApply  = 2'd2;
  localparam logic [1:0] SDrain  = 2'd3;

  logic [1:0]                          state_q, state_d;
  logic [tssi_pkg::CntW-1:0]           cnt_q, cnt_d;
  logic [tssi_pkg::CntW-1:0]           idx_q, idx_d;
  logic [tssi_pkg::CntW-1:0]           pos_q, pos_d;
  logic signed [tssi_pkg::ScoreW-1:0]  sc_q, sc_d;

  logic                                res_valid_q, res_valid_d;
  logic signed [tssi_pkg::ScoreW-1:0]  res_score_q, res_score_d;
  logic                                res_last_q, res_last_d;
  tssi_pkg::status_e                   res_status_q, res_status_d;
  logic [tssi_pkg::CntW-1:0]           res_cnt_q, res_cnt_d;

  tssi_pkg::store_cmd_t                cmd;
  logic signed [tssi_pkg::ScoreW-1:0]  rd_data;
  logic                                cmp_eq, cmp_gt;
  logic                                is_full;
  logic                                take;

  // Score store.
  tssi_store u_store (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .score_i   (sc_q),
    .rd_idx_i  (idx_q[tssi_pkg::IdxW-1:0]),
    .rd_data_o (rd_data)
  );

  // Shared comparator: the entry under the walk against the new score.
  assign cmp_eq  = (rd_data == sc_q);
  assign cmp_gt  = (rd_data > sc_q);
  assign is_full = (cnt_q == tssi_pkg::CntW'(tssi_pkg::MaxEntries));
  assign take    = start_i && !busy_o;

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    pos_d        = pos_q;
    sc_d         = sc_q;
    res_valid_d  = 1'b0;
    res_score_d  = res_score_q;
    res_last_d   = res_last_q;
    res_status_d = res_status_q;
    res_cnt_d    = res_cnt_q;
    cmd          = '0;
    case (state_q)
      SIdle: begin
        if (take) begin
          sc_d  = score_i;
          idx_d = '0;
          if (req_type_i == tssi_pkg::ReqInsert) begin
            state_d = SSearch;
          end else if (cnt_q != '0) begin
            state_d = SDrain;
          end
        end
      end
      SSearch: begin
        if (idx_q == cnt_q || cmp_gt) begin
          pos_d   = idx_q;
          state_d = SApply;
        end else if (cmp_eq) begin
          res_valid_d  = 1'b1;
          res_score_d  = '0;
          res_last_d   = 1'b1;
          res_status_d = tssi_pkg::StDuplicate;
          res_cnt_d    = cnt_q;
          state_d      = SIdle;
        end else begin
          idx_d = idx_q + tssi_pkg::CntW'(1);
        end
      end
      SApply: begin
        res_valid_d  = 1'b1;
        res_score_d  = '0;
        res_last_d   = 1'b1;
        res_status_d = tssi_pkg::StInserted;
        state_d      = SIdle;
        if (is_full) begin
          if (pos_q == '0) begin
            res_status_d = tssi_pkg::StTooLow;
          end else begin
            cmd.wr_en    = 1'b1;
            cmd.drop_low = 1'b1;
            cmd.slot     = tssi_pkg::IdxW'(pos_q - tssi_pkg::CntW'(1));
          end
          res_cnt_d = cnt_q;
        end else begin
          cmd.wr_en    = 1'b1;
          cmd.drop_low = 1'b0;
          cmd.slot     = tssi_pkg::IdxW'(pos_q);
          cnt_d        = cnt_q + tssi_pkg::CntW'(1);
          res_cnt_d    = cnt_q + tssi_pkg::CntW'(1);
        end
      end
      SDrain: begin
        res_valid_d  = 1'b1;
        res_score_d  = rd_data;
        res_status_d = tssi_pkg::StDrained;
        res_cnt_d    = cnt_q - idx_q - tssi_pkg::CntW'(1);
        res_last_d   = (idx_q == cnt_q - tssi_pkg::CntW'(1));
        if (idx_q == cnt_q - tssi_pkg::CntW'(1)) begin
          cnt_d   = '0;
          state_d = SIdle;
        end else begin
          idx_d = idx_q + tssi_pkg::CntW'(1);
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    pos_q        <= pos_d;
    sc_q         <= sc_d;
    res_score_q  <= res_score_d;
    res_last_q   <= res_last_d;
    res_status_q <= res_status_d;
    res_cnt_q    <= res_cnt_d;
  end

  // Ports.
  assign busy_o        = (state_q != SIdle);
  assign res_valid_o   = res_valid_q;
  assign score_out_o   = res_score_q;
  assign is_last_o     = res_last_q;
  assign status_o      = res_status_q;
  assign count_after_o = tssi_pkg::CntOutW'(res_cnt_q);

  // Assertions.
  `TSSI_ASSERT(a_cnt_bound, (cnt_q <= tssi_pkg::CntW'(tssi_pkg::MaxEntries)), "count exceeds capacity")
  `TSSI_ASSERT(a_last_idle, (res_valid_o && is_last_o) |-> !busy_o, "last beat while still busy")
  `TSSI_ASSERT(a_ins_shape, (res_valid_o && status_o != tssi_pkg::StDrained) |-> (is_last_o && score_out_o == '0), "insert result malformed")
  `TSSI_ASSERT(a_ins_busy, (take && req_type_i == tssi_pkg::ReqInsert) |=> busy_o, "insert not started")
  `TSSI_ASSERT(a_drain_run, (res_valid_o && status_o == tssi_pkg::StDrained && !is_last_o) |=> (res_valid_o && status_o == tssi_pkg::StDrained), "drain run broken")

endmodule
